>>> rtl/pdl_pkg.sv
// Shared types, widths and helpers for the positive-depth limiter pipeline.
package pdl_pkg;

  localparam int DW = 32;
  localparam int NW = 48;
  localparam int HW = 51;
  localparam int PW = 66;

  typedef enum logic [1:0] {
    REG_DRY_DEPTH = 2'd0,
    REG_VEL_ZERO  = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic [1:0][31:0] a;
    logic [1:0][30:0] b;
    logic [1:0][31:0] q;
    logic [1:0]       neg;
    logic             err;
    logic             last;
  } side1_t;

  typedef struct packed {
    logic [1:0][31:0] na;
    logic [1:0][31:0] q;
    logic [1:0]       wet;
    logic [1:0]       uneg;
    logic [1:0]       nz;
    logic             err;
    logic             last;
  } side2_t;

  function automatic logic [31:0] sat32(input logic neg, input logic [PW-1:0] m);
    logic [31:0] r;
    if (neg) begin
      if (m > PW'(64'h8000_0000)) r = 32'h8000_0000;
      else r = -m[31:0];
    end else begin
      if (m > PW'(64'h7FFF_FFFF)) r = 32'h7FFF_FFFF;
      else r = m[31:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/pdl_div.sv
// Two-lane pipelined restoring divider, one quotient bit per stage, with sideband.
module pdl_div import pdl_pkg::*; #(
  parameter int NW = 48,
  parameter int DW = 32,
  parameter int SW = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [1:0][NW-1:0]   num,
  input  logic [1:0][DW-1:0]   den,
  input  logic [SW-1:0]        side_in,
  output logic                 out_valid,
  output logic [1:0][NW-1:0]   quo,
  output logic [SW-1:0]        side_out
);

  logic [1:0][DW+NW-1:0] w  [NW];
  logic [1:0][DW-1:0]    d  [NW];
  logic [SW-1:0]         sd [NW];
  logic [NW-1:0]         vld;

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [1:0][DW+NW-1:0] w_src;
    logic [1:0][DW-1:0]    d_src;
    logic [SW-1:0]         s_src;
    logic                  v_src;
    logic [1:0][DW+NW-1:0] w_next;

    if (k == 0) begin : g_first
      always_comb begin
        for (int i = 0; i < 2; i++) begin
          w_src[i] = {{DW{1'b0}}, num[i]};
        end
      end
      assign d_src = den;
      assign s_src = side_in;
      assign v_src = in_valid;
    end else begin : g_rest
      assign w_src = w[k-1];
      assign d_src = d[k-1];
      assign s_src = sd[k-1];
      assign v_src = vld[k-1];
    end

    always_comb begin
      logic [DW+NW:0] s;
      logic [DW:0]    t;
      for (int i = 0; i < 2; i++) begin
        s = {w_src[i], 1'b0};
        t = s[DW+NW:NW];
        if (t >= {1'b0, d_src[i]}) begin
          t = t - {1'b0, d_src[i]};
          s[0] = 1'b1;
        end
        w_next[i] = {t[DW-1:0], s[NW-1:0]};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= v_src;
      end
      if (en) begin
        w[k]  <= w_next;
        d[k]  <= d_src;
        sd[k] <= s_src;
      end
    end
  end

  assign out_valid = vld[NW-1];
  assign side_out  = sd[NW-1];

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      quo[i] = w[NW-1][i][NW-1:0];
    end
  end

endmodule

>>> rtl/positive_depth_limiter_channel.sv
// Positive-depth limiter for one channel element, fully pipelined.
// One element is accepted per clock while in_ready is high; each result passes through
// two 48-stage pipelined dividers (for depth and for velocity) plus ten
// arithmetic stages. The whole pipeline advances together whenever the
// output register is empty or being taken, so throughput is one element per
// cycle while out_ready stays high.
module positive_depth_limiter_channel import pdl_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [30:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] area_left,
  input  logic signed [31:0] area_right,
  input  logic [30:0]        width_left,
  input  logic [30:0]        width_right,
  input  logic signed [31:0] flow_left,
  input  logic signed [31:0] flow_right,
  input  logic               last_element,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] new_area_left,
  output logic signed [31:0] new_area_right,
  output logic signed [31:0] new_flow_left,
  output logic signed [31:0] new_flow_right,
  output logic               width_error,
  output logic               last_result
);

  logic [30:0] dry_th;
  logic [30:0] vel_th;
  logic        en;
  logic [HW-1:0] hth;

  always_ff @(posedge clk) begin
    if (rst) begin
      dry_th <= 31'd66;
      vel_th <= 31'd66;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_DRY_DEPTH: dry_th <= cfg_data;
        REG_VEL_ZERO:  vel_th <= cfg_data;
        default: ;
      endcase
    end
  end

  assign en       = !out_valid || out_ready;
  assign in_ready = en;
  assign hth      = {20'b0, dry_th};

  // input to depth divider
  logic [1:0][31:0] a_in, q_in;
  logic [1:0][30:0] b_in;
  logic [1:0][NW-1:0] num1;
  logic [1:0][DW-1:0] den1;
  side1_t sd1_in;

  assign a_in = {area_right, area_left};
  assign q_in = {flow_right, flow_left};
  assign b_in = {width_right, width_left};

  always_comb begin
    logic [31:0] am;
    for (int i = 0; i < 2; i++) begin
      am = a_in[i][31] ? -a_in[i] : a_in[i];
      num1[i] = {am, 16'b0};
      den1[i] = {1'b0, b_in[i]};
    end
    sd1_in.a    = a_in;
    sd1_in.b    = b_in;
    sd1_in.q    = q_in;
    sd1_in.neg  = {a_in[1][31], a_in[0][31]};
    sd1_in.err  = (b_in[0] == 31'd0) || (b_in[1] == 31'd0);
    sd1_in.last = last_element;
  end

  logic               d1_v;
  logic [1:0][NW-1:0] d1_q;
  side1_t             d1_sd;

  pdl_div #(.NW(NW), .DW(DW), .SW($bits(side1_t))) u_div_depth (
    .clk, .rst, .en,
    .in_valid (in_valid),
    .num      (num1),
    .den      (den1),
    .side_in  (sd1_in),
    .out_valid(d1_v),
    .quo      (d1_q),
    .side_out (d1_sd)
  );

  // stage 1: signed depths, keep test, sum
  logic               v1, s1_keep, s1_le;
  logic [1:0][HW-1:0] s1_h;
  logic [HW-1:0]      s1_sum;
  side1_t             s1_sd;
  logic [1:0][HW-1:0] h_c;

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      h_c[i] = d1_sd.neg[i] ? -{3'b0, d1_q[i]} : {3'b0, d1_q[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= d1_v;
    if (en) begin
      s1_h    <= h_c;
      s1_keep <= ($signed(h_c[0]) >= $signed(hth)) && ($signed(h_c[1]) >= $signed(hth));
      s1_le   <= $signed(h_c[0]) <= $signed(h_c[1]);
      s1_sum  <= h_c[0] + h_c[1];
      s1_sd   <= d1_sd;
    end
  end

  // stage 2: limited depths
  logic               v2, s2_keep;
  logic [1:0][HW-1:0] s2_h;
  side1_t             s2_sd;
  logic [1:0][HW-1:0] hl_c;

  always_comb begin
    logic [HW-1:0] t, m, adj;
    t   = s1_sum + HW'(s1_sum[HW-1]);
    m   = {t[HW-1], t[HW-1:1]};
    adj = s1_sum - hth;
    if ($signed(m) <= $signed(hth)) begin
      hl_c[0] = m;
      hl_c[1] = m;
    end else if (s1_le) begin
      hl_c[0] = hth;
      hl_c[1] = adj;
    end else begin
      hl_c[0] = adj;
      hl_c[1] = hth;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
    if (en) begin
      s2_h    <= hl_c;
      s2_keep <= s1_keep;
      s2_sd   <= s1_sd;
    end
  end

  // stage 3: partial products depth * width
  logic             v3, s3_keep;
  logic [1:0][55:0] s3_plo, s3_phi;
  logic [1:0]       s3_neg;
  side1_t           s3_sd;
  logic [1:0][55:0] plo3_c, phi3_c;

  always_comb begin
    logic [HW-1:0] mh;
    for (int i = 0; i < 2; i++) begin
      mh = s2_h[i][HW-1] ? -s2_h[i] : s2_h[i];
      plo3_c[i] = 56'(mh[24:0]) * 56'(s2_sd.b[i]);
      phi3_c[i] = 56'(mh[49:25]) * 56'(s2_sd.b[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= v2;
    if (en) begin
      s3_plo  <= plo3_c;
      s3_phi  <= phi3_c;
      s3_neg  <= {s2_h[1][HW-1], s2_h[0][HW-1]};
      s3_keep <= s2_keep;
      s3_sd   <= s2_sd;
    end
  end

  // stage 4: rebuilt areas
  logic             v4;
  logic [1:0][31:0] s4_na;
  side1_t           s4_sd;
  logic [1:0][31:0] na4_c;

  always_comb begin
    logic [80:0] full;
    for (int i = 0; i < 2; i++) begin
      full = {s3_phi[i], 25'b0} + 81'(s3_plo[i]);
      na4_c[i] = (s3_keep || s3_sd.err) ? s3_sd.a[i] : sat32(s3_neg[i], PW'(full[80:16]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (en) v4 <= v3;
    if (en) begin
      s4_na <= na4_c;
      s4_sd <= s3_sd;
    end
  end

  // stage 5: wet bound (H+1)*b
  logic             v5;
  logic [1:0][62:0] s5_prod;
  logic [1:0][31:0] s5_na;
  side1_t           s5_sd;

  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else if (en) v5 <= v4;
    if (en) begin
      for (int i = 0; i < 2; i++) begin
        s5_prod[i] <= 63'({1'b0, dry_th} + 32'd1) * 63'(s4_sd.b[i]);
      end
      s5_na <= s4_na;
      s5_sd <= s4_sd;
    end
  end

  // stage 6: wetness and velocity divider operands
  logic               v6;
  logic [1:0][NW-1:0] s6_num;
  logic [1:0][DW-1:0] s6_den;
  side2_t             s6_sd;
  logic [1:0][NW-1:0] num6_c;
  logic [1:0][DW-1:0] den6_c;
  side2_t             sd6_c;

  always_comb begin
    logic [31:0] qm;
    for (int i = 0; i < 2; i++) begin
      qm = s5_sd.q[i][31] ? -s5_sd.q[i] : s5_sd.q[i];
      num6_c[i] = {qm, 16'b0};
      den6_c[i] = s5_na[i][31] ? -s5_na[i] : s5_na[i];
      sd6_c.wet[i]  = !s5_na[i][31] && (s5_na[i] != 32'd0) &&
                      ({15'b0, s5_na[i], 16'b0} >= s5_prod[i]);
      sd6_c.uneg[i] = s5_sd.q[i][31] ^ s5_na[i][31];
      sd6_c.nz[i]   = s5_na[i] != 32'd0;
    end
    sd6_c.na   = s5_na;
    sd6_c.q    = s5_sd.q;
    sd6_c.err  = s5_sd.err;
    sd6_c.last = s5_sd.last;
  end

  always_ff @(posedge clk) begin
    if (rst) v6 <= 1'b0;
    else if (en) v6 <= v5;
    if (en) begin
      s6_num <= num6_c;
      s6_den <= den6_c;
      s6_sd  <= sd6_c;
    end
  end

  logic               d2_v;
  logic [1:0][NW-1:0] d2_q;
  side2_t             d2_sd;

  pdl_div #(.NW(NW), .DW(DW), .SW($bits(side2_t))) u_div_vel (
    .clk, .rst, .en,
    .in_valid (v6),
    .num      (s6_num),
    .den      (s6_den),
    .side_in  (s6_sd),
    .out_valid(d2_v),
    .quo      (d2_q),
    .side_out (d2_sd)
  );

  // stage 7: signed velocities, donor flags
  logic               v7;
  logic [1:0][HW-1:0] s7_u;
  logic [1:0]         s7_give;
  side2_t             s7_sd;

  always_ff @(posedge clk) begin
    logic [31:0] qm;
    if (rst) v7 <= 1'b0;
    else if (en) v7 <= d2_v;
    if (en) begin
      for (int i = 0; i < 2; i++) begin
        qm = d2_sd.q[i][31] ? -d2_sd.q[i] : d2_sd.q[i];
        if (!d2_sd.nz[i]) s7_u[i] <= '0;
        else s7_u[i] <= d2_sd.uneg[i] ? -{3'b0, d2_q[i]} : {3'b0, d2_q[i]};
        s7_give[i] <= !d2_sd.wet[i] && (qm > {1'b0, vel_th});
      end
      s7_sd <= d2_sd;
    end
  end

  // stage 8: redistributed velocities
  logic               v8;
  logic [1:0][HW-1:0] s8_v;
  logic [1:0][31:0]   s8_am;
  side2_t             s8_sd;

  always_ff @(posedge clk) begin
    logic [HW-1:0] dv;
    if (rst) v8 <= 1'b0;
    else if (en) v8 <= v7;
    if (en) begin
      dv = (s7_give[0] ? s7_u[0] : '0) + (s7_give[1] ? s7_u[1] : '0);
      for (int i = 0; i < 2; i++) begin
        s8_v[i]  <= s7_sd.wet[i] ? s7_u[i] + dv : '0;
        s8_am[i] <= s7_sd.na[i][31] ? -s7_sd.na[i] : s7_sd.na[i];
      end
      s8_sd <= s7_sd;
    end
  end

  // stage 9: partial products area * velocity
  logic             v9;
  logic [1:0][56:0] s9_plo, s9_phi;
  logic [1:0]       s9_neg;
  side2_t           s9_sd;

  always_ff @(posedge clk) begin
    logic [HW-1:0] mv;
    if (rst) v9 <= 1'b0;
    else if (en) v9 <= v8;
    if (en) begin
      for (int i = 0; i < 2; i++) begin
        mv = s8_v[i][HW-1] ? -s8_v[i] : s8_v[i];
        s9_plo[i] <= 57'(mv[24:0]) * 57'(s8_am[i]);
        s9_phi[i] <= 57'(mv[49:25]) * 57'(s8_am[i]);
        s9_neg[i] <= s8_v[i][HW-1] ^ s8_sd.na[i][31];
      end
      s9_sd <= s8_sd;
    end
  end

  // stage 10: output register
  logic [1:0][31:0] nq_c;

  always_comb begin
    logic [81:0] full;
    for (int i = 0; i < 2; i++) begin
      full = {s9_phi[i], 25'b0} + 82'(s9_plo[i]);
      nq_c[i] = s9_sd.err ? s9_sd.q[i] : sat32(s9_neg[i], full[81:16]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= v9;
    if (en) begin
      new_area_left  <= s9_sd.na[0];
      new_area_right <= s9_sd.na[1];
      new_flow_left  <= nq_c[0];
      new_flow_right <= nq_c[1];
      width_error    <= s9_sd.err;
      last_result    <= s9_sd.last;
    end
  end

endmodule

>>> rtl/pdl_checker.sv
// Port-level checks for the depth limiter, bound to the top level.
module pdl_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] new_area_left,
  input logic [31:0] new_flow_left,
  input logic        width_error,
  input logic        last_result
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(new_area_left) &&
      $stable(new_flow_left) && $stable(width_error) && $stable(last_result))
    else $error("stalled result changed");

  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  a_ready_taken: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready |-> in_ready)
    else $error("input stalled while result is transferred");

  a_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while pipeline is stalled");

endmodule

bind positive_depth_limiter_channel pdl_checker u_pdl_checker (.*);

>>> sim/positive_depth_limiter_channel_checker.sv
// Checker for the positive-depth limiter: predicts each element's result and compares.
module positive_depth_limiter_channel_checker import pdl_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [30:0]        cfg_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [31:0] area_left,
  input  logic signed [31:0] area_right,
  input  logic [30:0]        width_left,
  input  logic [30:0]        width_right,
  input  logic signed [31:0] flow_left,
  input  logic signed [31:0] flow_right,
  input  logic               last_element,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] new_area_left,
  input  logic signed [31:0] new_area_right,
  input  logic signed [31:0] new_flow_left,
  input  logic signed [31:0] new_flow_right,
  input  logic               width_error,
  input  logic               last_result,
  output int                 fail_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [31:0] al;
    logic signed [31:0] ar;
    logic signed [31:0] fl;
    logic signed [31:0] fr;
    logic               err;
    logic               last;
  } limited_t;

  limited_t limited_q[$];
  longint dry_depth, vel_zero;

  function automatic longint sat_word(longint x);
    if (x > 64'sh7FFFFFFF) return 64'sh7FFFFFFF;
    if (x < -64'sh80000000) return -64'sh80000000;
    return x;
  endfunction

  function automatic longint qmul(longint a, longint b);
    logic [63:0] ma, mb, p;
    logic neg;
    ma = a < 0 ? -a : a;
    mb = b < 0 ? -b : b;
    neg = (a < 0) != (b < 0);
    if (ma != 0 && mb > 64'h4000000000000000 / ma) p = 64'h100000000;
    else p = (ma * mb) >> 16;
    if (p > 64'h100000000) p = 64'h100000000;
    return sat_word(neg ? -longint'(p) : longint'(p));
  endfunction

  function automatic longint qdiv(longint a, longint d);
    return (a * 65536) / d;
  endfunction

  function automatic limited_t limit_element(longint a0, longint a1, longint b0, longint b1,
                                             longint q0, longint q1, logic lst);
    limited_t r;
    longint h0, h1, m, na0, na1, u0, u1, d, n, v0, v1;
    logic w0, w1;
    r.last = lst;
    r.err = (b0 == 0 || b1 == 0);
    if (r.err) begin
      r.al = 32'(a0); r.ar = 32'(a1); r.fl = 32'(q0); r.fr = 32'(q1);
      return r;
    end
    h0 = qdiv(a0, b0);
    h1 = qdiv(a1, b1);
    m = (h0 + h1) / 2;
    if (h0 >= dry_depth && h1 >= dry_depth) begin
      na0 = a0; na1 = a1;
    end else begin
      if (m <= dry_depth) begin
        h0 = m; h1 = m;
      end else if (h0 <= h1) begin
        h1 -= dry_depth - h0; h0 = dry_depth;
      end else begin
        h0 -= dry_depth - h1; h1 = dry_depth;
      end
      na0 = qmul(h0, b0);
      na1 = qmul(h1, b1);
    end
    w0 = qdiv(na0, b0) > dry_depth;
    w1 = qdiv(na1, b1) > dry_depth;
    u0 = na0 != 0 ? qdiv(q0, na0) : 0;
    u1 = na1 != 0 ? qdiv(q1, na1) : 0;
    r.al = 32'(na0); r.ar = 32'(na1);
    if (!w0 && !w1) begin
      r.fl = 0; r.fr = 0;
    end else begin
      d = 0;
      n = longint'(w0) + longint'(w1);
      if (!w0 && (q0 < 0 ? -q0 : q0) > vel_zero) d += u0;
      if (!w1 && (q1 < 0 ? -q1 : q1) > vel_zero) d += u1;
      v0 = w0 ? u0 + d / n : 0;
      v1 = w1 ? u1 + d / n : 0;
      r.fl = 32'(qmul(na0, v0));
      r.fr = 32'(qmul(na1, v1));
    end
    return r;
  endfunction

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t %s expected %h actual %h", $time, name, want, got);
      fail_count++;
    end
  endtask

  assign pending = limited_q.size();

  always @(posedge clk) begin
    limited_t e;
    if (rst) begin
      dry_depth <= 66;
      vel_zero <= 66;
      fail_count = 0;
    end else begin
      if (cfg_we && cfg_index == REG_DRY_DEPTH) dry_depth <= longint'(cfg_data);
      if (cfg_we && cfg_index == REG_VEL_ZERO) vel_zero <= longint'(cfg_data);
      if (in_valid && in_ready)
        limited_q.push_back(limit_element(longint'(area_left), longint'(area_right),
                                          longint'(width_left), longint'(width_right),
                                          longint'(flow_left), longint'(flow_right),
                                          last_element));
      if (out_valid && out_ready) begin
        if (limited_q.size() == 0) begin
          $display("%0t unexpected result expected none actual %h", $time, new_area_left);
          fail_count++;
        end else begin
          e = limited_q.pop_front();
          compare_field("new_area_left", e.al, new_area_left);
          compare_field("new_area_right", e.ar, new_area_right);
          compare_field("new_flow_left", e.fl, new_flow_left);
          compare_field("new_flow_right", e.fr, new_flow_right);
          compare_field("width_error", 32'(e.err), 32'(width_error));
          compare_field("last_result", 32'(e.last), 32'(last_result));
        end
      end
    end
  end
endmodule

>>> sim/positive_depth_limiter_channel_test.sv
// Testbench top: drives elements and settings into the limiter and reports the verdict.
module positive_depth_limiter_channel_test import pdl_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 0, rst = 1;
  logic cfg_we = 0;
  logic [1:0] cfg_index = REG_DRY_DEPTH;
  logic [30:0] cfg_data = 0;
  logic in_valid = 0, in_ready, out_valid, out_ready = 0;
  logic signed [31:0] area_left = 0, area_right = 0, flow_left = 0, flow_right = 0;
  logic [30:0] width_left = 0, width_right = 0;
  logic last_element = 0;
  logic signed [31:0] new_area_left, new_area_right, new_flow_left, new_flow_right;
  logic width_error, last_result;
  int fail_count, pending, idle_cycles;
  logic done = 0;

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  positive_depth_limiter_channel DUT (.*);
  positive_depth_limiter_channel_checker checker_i (.*);

  always @(posedge clk) begin
    if (rst) out_ready <= 0;
    else if (($time / 600) % 4 == 3) out_ready <= 1;
    else out_ready <= ($urandom_range(0, 9) < 6);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_element(logic [31:0] a0, logic [31:0] a1, logic [30:0] b0,
                              logic [30:0] b1, logic [31:0] q0, logic [31:0] q1);
    area_left <= a0; area_right <= a1; width_left <= b0; width_right <= b1;
    flow_left <= q0; flow_right <= q1; last_element <= 1'($urandom_range(0, 1));
    in_valid <= 1;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic pause_sender();
    in_valid <= 0;
    repeat ($urandom_range(1, 6)) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (70) @(posedge clk);
  endtask

  task automatic write_setting(cfg_reg_t idx, logic [30:0] val);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  function automatic logic [31:0] pick_depth_area(logic [30:0] b, logic [30:0] h);
    longint a;
    a = (longint'(h) * longint'(b)) >>> 16;
    if ($urandom_range(0, 1)) a = -a;
    return sat_word_tb(a);
  endfunction

  function automatic logic [31:0] sat_word_tb(longint a);
    if (a > 64'sh7FFFFFFF) return 32'h7FFFFFFF;
    if (a < -64'sh80000000) return 32'h80000000;
    return 32'(a);
  endfunction

  task automatic random_element(logic [30:0] h);
    logic [30:0] b0, b1;
    int sel;
    sel = $urandom_range(0, 9);
    b0 = 31'(sel < 7 ? $urandom_range(1, 32'h40000) : $urandom);
    b1 = 31'(sel < 7 ? $urandom_range(1, 32'h40000) : $urandom);
    if (sel == 9) begin
      if ($urandom_range(0, 1)) b0 = 0; else b1 = 0;
    end
    if (sel < 6)
      send_element(
        pick_depth_area(b0, 31'($urandom_range(0, 3) == 0 ? $urandom
                                                         : $urandom_range(0, 3 * h + 8))),
        pick_depth_area(b1, 31'($urandom_range(0, 3 * h + 8))),
        b0, b1, $urandom, $urandom_range(0, 1) ? $urandom : $urandom_range(0, 200));
    else
      send_element($urandom, $urandom, b0, b1, $urandom, $urandom);
  endtask

  initial begin
    logic [30:0] depths[4];
    logic [30:0] vels[4];
    int phase;
    depths = '{66, 0, 31'h7FFFFFFF, 31'h10000};
    vels = '{66, 31'h7FFFFFFF, 0, 31'h8000};
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    send_element(32'h7FFFFFFF, 32'h80000000, 31'h7FFFFFFF, 1, 32'h7FFFFFFF, 32'h80000000);
    send_element(0, 0, 31'h10000, 31'h10000, 32'h100, 32'hFFFFFF00);
    send_element(32'h10000, 20, 31'h10000, 31'h10000, 32'h5000, 32'h5000);
    send_element(10, 32'h10000, 31'h10000, 31'h10000, 1000, 1000);
    send_element(30, 30, 31'h10000, 31'h10000, 500, 500);
    send_element(32'h100000, 32'h200000, 31'h10000, 31'h10000, 32'h30000, 32'hFFFD0000);
    send_element(32'h1000, 32'h1000, 0, 31'h10000, 7, 9);
    send_element(32'h1000, 32'h1000, 31'h10000, 0, 7, 9);
    send_element(0, 32'h80000, 31'h10000, 31'h10000, 32'h40000, 1);
    send_element(32'h80000000, 32'h7FFFFFFF, 1, 1, 32'h80000000, 32'h7FFFFFFF);
    send_element(50, 40, 31'h10000, 31'h10000, 32'hFFFFFFFF, 32'h7FFFFFFF);
    send_element(66, 66, 31'h10000, 31'h10000, 67, 65);
    send_element(32'hFFFF0000, 32'h30000, 31'h10000, 31'h10000, 32'h10000, 32'h10000);
    drain();
    for (phase = 0; phase < 4; phase++) begin
      write_setting(REG_DRY_DEPTH, depths[phase]);
      write_setting(REG_VEL_ZERO, vels[phase]);
      repeat (370) begin
        if ($urandom_range(0, 7) == 0) pause_sender();
        random_element(depths[phase] > 31'h100000 ? 31'h100000 : depths[phase]);
      end
      drain();
    end
    write_setting(REG_DRY_DEPTH, 31'($urandom));
    write_setting(REG_VEL_ZERO, 31'($urandom));
    repeat (100) random_element(31'h400);
    drain();
    done <= 1;
  end

  always @(posedge clk) begin
    if (done) begin
      if (fail_count == 0 && pending == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
    end
  end
endmodule
